@@ src/urf_pkg.sv @@
// shared types and constants for the uart register window with receive fifo
// no dependencies
package urf_pkg;

  // default receive fifo depth in entries (holds one less than this)
  localparam int unsigned FifoDepthDefault = 256;

  // register window layout and line status codes
  localparam logic [2:0] LsrOffset = 3'd5;
  localparam logic [7:0] LsrReady  = 8'h21;
  localparam logic [7:0] LsrIdle   = 8'h20;
  localparam logic [7:0] EmptyByte = 8'hFF;

  // item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OpRxByte = 2'd0,
    OpWrite  = 2'd1,
    OpRead   = 2'd2
  } op_e;

  // fifo request from the register window logic
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } fifo_cmd_t;

  // fifo occupancy as seen by the register window logic
  typedef struct packed {
    logic empty;
    logic single;
  } fifo_stat_t;

  // one result transaction
  typedef struct packed {
    logic       bad_offset;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] read_data;
  } result_t;

endpackage

@@ src/urf_ram.sv @@
// generic single write port ram with one registered read port
// no dependencies
module urf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read, read returns old data on a collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/urf_rx_fifo.sv @@
// receive ring fifo: pointers, storage ram and head-of-queue bypass
// depends on urf_pkg and urf_ram
module urf_rx_fifo #(
  parameter int unsigned FifoDepth = urf_pkg::FifoDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  urf_pkg::fifo_cmd_t     cmd_i,
  output urf_pkg::fifo_stat_t    stat_o,
  output logic [7:0]             head_o
);
  import urf_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FifoDepth - 1);

  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW-1:0] wptr_nxt, rptr_nxt;
  logic            full, we;
  logic            byp_q, byp_d;
  logic [7:0]      byp_data_q;
  logic [7:0]      ram_rdata;

  // ring increments
  assign wptr_nxt = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
  assign rptr_nxt = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;

  // occupancy
  assign full          = (wptr_nxt == rptr_q);
  assign stat_o.empty  = (wptr_q == rptr_q);
  assign stat_o.single = (rptr_nxt == wptr_q);

  // pointer updates, a push into a full fifo is dropped
  assign we     = cmd_i.push && !full;
  assign wptr_d = we ? wptr_nxt : wptr_q;
  assign rptr_d = (cmd_i.pop && !stat_o.empty) ? rptr_nxt : rptr_q;

  // a byte written to the next head slot is not yet visible on the read port
  assign byp_d = we && (wptr_q == rptr_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      byp_q  <= 1'b0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      byp_q  <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= cmd_i.data;
  end

  // storage, read address tracks the head for the next cycle
  urf_ram #(
    .Width (8),
    .Depth (FifoDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wptr_q),
    .wdata_i (cmd_i.data),
    .raddr_i (rptr_d),
    .rdata_o (ram_rdata)
  );

  assign head_o = byp_q ? byp_data_q : ram_rdata;

endmodule

@@ src/urf_regfile.sv @@
// eight byte register window and the decode of one item into a result
// depends on urf_pkg
module urf_regfile (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  logic [1:0]          op_i,
  input  logic [2:0]          offset_i,
  input  logic [7:0]          data_i,
  input  logic                soc_mode_i,
  input  urf_pkg::fifo_stat_t stat_i,
  input  logic [7:0]          head_i,
  output urf_pkg::fifo_cmd_t  cmd_o,
  output urf_pkg::result_t    res_o
);
  import urf_pkg::*;

  logic [7:0] win_q [8];
  logic [7:0] win_d [8];
  logic [7:0] pop_byte;
  logic       is_wr;

  assign pop_byte = stat_i.empty ? EmptyByte : head_i;
  assign is_wr    = (op_e'(op_i) == OpWrite);

  // decode the item, update the window and form the result
  always_comb begin
    win_d = win_q;
    cmd_o = '0;
    res_o = '0;
    cmd_o.data = data_i;
    if (go_i) begin
      case (op_e'(op_i))
        OpRxByte: begin
          cmd_o.push = 1'b1;
        end
        OpWrite, OpRead: begin
          if (offset_i != 3'd0 && !soc_mode_i) begin
            res_o.bad_offset = 1'b1;
          end else if (offset_i == 3'd0) begin
            if (is_wr) begin
              win_d[0]       = data_i;
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = data_i;
            end else begin
              cmd_o.pop       = !stat_i.empty;
              win_d[0]        = pop_byte;
              win_d[LsrOffset] = (!stat_i.empty && !stat_i.single) ? LsrReady : LsrIdle;
              res_o.read_data = pop_byte;
            end
          end else begin
            if (is_wr) begin
              win_d[offset_i] = data_i;
            end
            if (offset_i == LsrOffset) begin
              win_d[LsrOffset] = stat_i.empty ? LsrIdle : LsrReady;
            end
            if (!is_wr) begin
              res_o.read_data = win_d[offset_i];
            end
          end
        end
        default: begin
          res_o = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      win_q <= win_d;
    end
  end

endmodule

@@ src/uart_rx_fifo_registers.sv @@
// throughput: one item per cycle while the result output is not stalled
// stages: input register, one decode stage, result register
// the receive fifo ram has a registered read; a head bypass keeps pops at full rate
// reset: asynchronous active low, clears pointers, window, soc mode and valid flags
// no clearing pass: fifo storage is only read after it is written
// depends on urf_pkg, urf_rx_fifo, urf_regfile
module uart_rx_fifo_registers #(
  parameter int unsigned FifoDepth = urf_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // soc_mode
  // item input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [2:0] offset, [10:3] data, [15:11] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] read_data, [15:8] tx_byte
  output logic [1:0]  m_axis_tuser    // [0] tx_valid, [1] bad_offset
);
  import urf_pkg::*;

  logic       soc_mode_q;
  logic       in_vld_q, out_vld_q;
  logic [1:0] op_q;
  logic [2:0] off_q;
  logic [7:0] data_q;
  logic       go, in_acc;
  fifo_cmd_t  fcmd;
  fifo_stat_t fstat;
  logic [7:0] head;
  result_t    res, res_q;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soc_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      soc_mode_q <= cfg_data_i;
    end
  end

  // stage handshakes
  assign go            = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || go;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (go) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // input and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser;
      off_q  <= s_axis_tdata[2:0];
      data_q <= s_axis_tdata[10:3];
    end
    if (go) begin
      res_q <= res;
    end
  end

  urf_rx_fifo #(
    .FifoDepth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (fcmd),
    .stat_o (fstat),
    .head_o (head)
  );

  urf_regfile u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .op_i       (op_q),
    .offset_i   (off_q),
    .data_i     (data_q),
    .soc_mode_i (soc_mode_q),
    .stat_i     (fstat),
    .head_i     (head),
    .cmd_o      (fcmd),
    .res_o      (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {res_q.tx_byte, res_q.read_data};
  assign m_axis_tuser  = {res_q.bad_offset, res_q.tx_valid};

endmodule

@@ src/urf_checker.sv @@
// port level checks for uart_rx_fifo_registers, attached by bind
// depends on uart_rx_fifo_registers port list only
module urf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // no result is offered while in reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // a transmitted byte comes with no read data and no error
  a_tx_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0 && !m_axis_tuser[1])
    else $error("transmit transaction carries read data or error");

  // a flagged access returns nothing
  a_bad_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 16'd0)
    else $error("flagged access returns data");

  // transmit byte is zero unless a byte is sent
  a_tx_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:8] == 8'd0)
    else $error("transmit byte set without transmit");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind uart_rx_fifo_registers urf_checker u_urf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ dv/uart_rx_fifo_registers_tb.sv @@
// self-checking testbench for uart_rx_fifo_registers: line bytes, bus writes and reads
// checked against a cycle-free model of the register window and receive fifo
// depends on urf_pkg and the uart_rx_fifo_registers rtl
module uart_rx_fifo_registers_tb;
  import urf_pkg::*;

  localparam int unsigned FifoDepth = FifoDepthDefault;
  // data register offset and the item kind that the block ignores
  localparam logic [2:0] RbrOffset = 3'd0;
  localparam logic [1:0] OpUnused  = 2'd3;
  localparam int unsigned IdlePct  = 17;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] offset;
    logic [7:0] data;
  } line_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [2:0] offset, [10:3] data, [15:11] zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] read_data, [15:8] tx_byte
  logic [1:0]  m_axis_tuser;        // [0] tx_valid, [1] bad_offset

  // stimulus and scoreboard state
  line_item_t items_to_send[$];
  result_t    results_due[$];
  line_item_t cur_item;
  result_t    want;
  int unsigned mismatches = 0;
  bit         calm = 1'b0;
  bit         hold_armed = 1'b0;
  bit         hold_done;
  int unsigned hold_left;

  // model state
  logic [7:0]  rx_mem [FifoDepth];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  logic [7:0]  window [8] = '{default: 8'h00};
  logic        soc_mode = 1'b0;

  uart_rx_fifo_registers uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // advance the uart model by one item and return the result it causes
  function automatic result_t uart_step(line_item_t it);
    result_t r;
    bit      wr_access;
    r = '0;
    wr_access = (it.op == OpWrite);
    case (it.op)
      OpRxByte: begin
        // a full fifo drops the byte
        if ((wr_ptr + 1) % FifoDepth != rd_ptr) begin
          rx_mem[wr_ptr] = it.data;
          wr_ptr = (wr_ptr + 1) % FifoDepth;
        end
      end
      OpWrite, OpRead: begin
        if (it.offset != RbrOffset && !soc_mode) begin
          r.bad_offset = 1'b1;
        end else if (it.offset == RbrOffset) begin
          if (wr_access) begin
            window[RbrOffset] = it.data;
            r.tx_valid = 1'b1;
            r.tx_byte = it.data;
          end else begin
            if (wr_ptr == rd_ptr) begin
              window[RbrOffset] = EmptyByte;
            end else begin
              window[RbrOffset] = rx_mem[rd_ptr];
              rd_ptr = (rd_ptr + 1) % FifoDepth;
            end
            window[LsrOffset] = (wr_ptr != rd_ptr) ? LsrReady : LsrIdle;
            r.read_data = window[RbrOffset];
          end
        end else begin
          if (wr_access) window[it.offset] = it.data;
          if (it.offset == LsrOffset) window[LsrOffset] = (wr_ptr != rd_ptr) ? LsrReady : LsrIdle;
          if (!wr_access) r.read_data = window[it.offset];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // random item; rx_pct and rd_pct set the mix, the rest are writes and a few unused ops
  function automatic line_item_t random_item(int unsigned rx_pct, int unsigned rd_pct);
    line_item_t  it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < rx_pct) it.op = OpRxByte;
    else if (pick < rx_pct + rd_pct) it.op = OpRead;
    else if (pick < 96) it.op = OpWrite;
    else it.op = OpUnused;
    it.offset = ($urandom_range(0, 99) < 55) ? RbrOffset : 3'($urandom_range(1, 7));
    it.data = 8'($urandom);
    return it;
  endfunction

  task automatic add(logic [1:0] op, logic [2:0] offset, logic [7:0] data);
    line_item_t it;
    it.op = op;
    it.offset = offset;
    it.data = data;
    items_to_send.push_back(it);
  endtask

  task automatic add_random(int unsigned count, int unsigned rx_pct, int unsigned rd_pct);
    repeat (count) items_to_send.push_back(random_item(rx_pct, rd_pct));
  endtask

  // block until every item went out and every result came back
  task automatic drain();
    while (items_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0)
      @(posedge clk_i);
  endtask

  // soc mode is only changed while the block is idle
  task automatic write_soc_mode(logic value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    soc_mode = value;
    cfg_valid_i <= 1'b0;
  endtask

  // driver: present queued items, hold each until its transaction completes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) results_due.push_back(uart_step(cur_item));
      if (items_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        cur_item = items_to_send.pop_front();
        s_axis_tdata <= {5'b0, cur_item.data, cur_item.offset};
        s_axis_tuser <= cur_item.op;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result transaction: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (m_axis_tdata[7:0] !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, m_axis_tdata[7:0]);
            mismatches++;
          end
          if (m_axis_tuser[0] !== want.tx_valid) begin
            $error("tx_valid: expected %b, got %b", want.tx_valid, m_axis_tuser[0]);
            mismatches++;
          end
          if (m_axis_tdata[15:8] !== want.tx_byte) begin
            $error("tx_byte: expected %h, got %h", want.tx_byte, m_axis_tdata[15:8]);
            mismatches++;
          end
          if (m_axis_tuser[1] !== want.bad_offset) begin
            $error("bad_offset: expected %b, got %b", want.bad_offset, m_axis_tuser[1]);
            mismatches++;
          end
        end
      end
      // one long hold-off so the pipeline backs up into the input
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // stimulus sequence
  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // soc mode off: empty pop, transmit, flagged offsets, unused op, fifo order
    add(OpRead, RbrOffset, 8'h00);
    add(OpWrite, RbrOffset, 8'h00);
    add(OpWrite, RbrOffset, 8'hFF);
    add(OpWrite, 3'd3, 8'hFF);
    add(OpRead, 3'd7, 8'h00);
    add(OpWrite, LsrOffset, 8'h55);
    add(OpUnused, 3'd7, 8'hFF);
    add(OpRxByte, 3'd7, 8'h00);
    add(OpRxByte, RbrOffset, 8'hFF);
    add(OpRxByte, 3'd2, 8'hA5);
    repeat (4) add(OpRead, RbrOffset, 8'h00);
    write_soc_mode(1'b1);

    // soc mode on: status reads and writes, other offsets, status refresh timing
    add(OpRead, LsrOffset, 8'h00);
    add(OpWrite, LsrOffset, 8'hFF);
    add(OpRead, LsrOffset, 8'h00);
    add(OpWrite, 3'd1, 8'hFF);
    add(OpWrite, 3'd7, 8'h00);
    add(OpWrite, 3'd7, 8'h81);
    add(OpRead, 3'd1, 8'h00);
    add(OpRead, 3'd7, 8'h00);
    add(OpRead, 3'd2, 8'h00);
    add(OpRxByte, 3'd5, 8'h3C);
    add(OpRead, LsrOffset, 8'h00);
    add(OpRead, RbrOffset, 8'h00);
    add(OpRead, LsrOffset, 8'h00);
    add(OpUnused, RbrOffset, 8'h00);
    write_soc_mode(1'b0);

    // random traffic with soc mode off, then with soc mode on
    add_random(150, 40, 30);
    write_soc_mode(1'b1);
    add_random(150, 40, 30);
    drain();

    // flood the fifo past full while the receiver holds off, then read the status and twenty bytes back
    calm = 1'b1;
    hold_armed = 1'b1;
    repeat (265) add(OpRxByte, 3'($urandom_range(0, 7)), 8'($urandom));
    add(OpRead, LsrOffset, 8'h00);
    repeat (20) add(OpRead, RbrOffset, 8'h00);
    drain();
    calm = 1'b0;

    write_soc_mode(1'b0);
    add_random(100, 20, 60);
    write_soc_mode(1'b1);
    add_random(100, 30, 50);
    drain();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("** uart_rx_fifo_registers: PASSED **");
    end else begin
      $display("** uart_rx_fifo_registers: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("** uart_rx_fifo_registers: FAILED **");
    $finish;
  end

endmodule
